// ----- src/mf3_pkg.sv -----
// Shared types and constants of the 3x3 RGB median filter.
package mf3_pkg;

  localparam int PIX_W   = 24;
  localparam int CH_W    = 8;
  localparam int WIN_N   = 9;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 16;
  localparam int CFG_W   = 16;
  localparam int FW_W    = 11;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             run_last;
    logic             frame_last;
  } rsl_ctl_t;

endpackage

// ----- src/mf3_ram.sv -----
// Generic simple dual-port RAM with registered read.
module mf3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/mf3_median.sv -----
// Three-stage rank-select median pipeline for one clipped window.
module mf3_median (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                i_valid,
  output logic                i_ready,
  input  mf3_pkg::win_t       i_win,
  input  logic [8:0]          i_mask,
  input  logic [3:0]          i_cnt,
  input  mf3_pkg::rsl_ctl_t   i_ctl,
  output logic                o_valid,
  input  logic                o_ready,
  output logic [2:0][7:0]     o_med,
  output mf3_pkg::rsl_ctl_t   o_ctl
);
  import mf3_pkg::*;

  logic a_v_r, b_v_r, o_v_r;
  logic a_en, b_en, c_en;

  win_t       a_win_r, b_win_r;
  logic [8:0] a_mask_r, b_mask_r;
  logic [3:0] a_cnt_r, b_cnt_r;
  rsl_ctl_t   a_ctl_r, b_ctl_r, o_ctl_r;
  logic [2:0][8:0][3:0] rank_nxt, b_rank_r;
  logic [2:0][7:0] med_nxt, o_med_r;

  assign c_en    = !o_v_r || o_ready;
  assign b_en    = !b_v_r || c_en;
  assign a_en    = !a_v_r || b_en;
  assign i_ready = a_en;

  always_comb begin
    logic [CH_W-1:0] vi, vj;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < WIN_N; i++) begin
        rank_nxt[k][i] = '0;
        vi = a_win_r[i][CH_W*k +: CH_W];
        for (int j = 0; j < WIN_N; j++) begin
          vj = a_win_r[j][CH_W*k +: CH_W];
          if (j != i && a_mask_r[j] && ((vj < vi) || (vj == vi && j < i))) begin
            rank_nxt[k][i] = rank_nxt[k][i] + 4'd1;
          end
        end
      end
    end
  end

  always_comb begin
    logic [3:0] ka, kb;
    logic [CH_W-1:0] lo, hi;
    logic [CH_W:0] sum;
    ka = (b_cnt_r - 4'd1) >> 1;
    kb = b_cnt_r >> 1;
    for (int k = 0; k < 3; k++) begin
      lo = '0;
      hi = '0;
      for (int i = 0; i < WIN_N; i++) begin
        if (b_mask_r[i] && b_rank_r[k][i] == ka) begin
          lo = lo | b_win_r[i][CH_W*k +: CH_W];
        end
        if (b_mask_r[i] && b_rank_r[k][i] == kb) begin
          hi = hi | b_win_r[i][CH_W*k +: CH_W];
        end
      end
      sum = {1'b0, lo} + {1'b0, hi};
      med_nxt[k] = sum[CH_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (a_en) begin
        a_v_r <= i_valid;
      end
      if (b_en) begin
        b_v_r <= a_v_r;
      end
      if (c_en) begin
        o_v_r <= b_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_win_r  <= i_win;
      a_mask_r <= i_mask;
      a_cnt_r  <= i_cnt;
      a_ctl_r  <= i_ctl;
    end
    if (b_en) begin
      b_win_r  <= a_win_r;
      b_mask_r <= a_mask_r;
      b_cnt_r  <= a_cnt_r;
      b_ctl_r  <= a_ctl_r;
      b_rank_r <= rank_nxt;
    end
    if (c_en) begin
      o_med_r <= med_nxt;
      o_ctl_r <= b_ctl_r;
    end
  end

  assign o_valid = o_v_r;
  assign o_med   = o_med_r;
  assign o_ctl   = o_ctl_r;

endmodule

// ----- src/median_filter_3x3_rgb_unit.sv -----
// Top level of the 3x3 RGB median filter with line stores and window sequencer.
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tdata: blue, green, red
//  out_    | out | out_tvalid/out_tready | tdata: col, row, blue, green, red;
//          |     |                       | tlast: run_last; tuser: frame_last
//  cfg_    | in  | cfg_we                | cfg_addr, cfg_wdata
//
// One pixel is taken per cycle while the line store stage can move on; each pixel
// waits in that stage for the line store read, then its results issue one per
// cycle, unless the median pipe stalls, into a three-stage median pipe. Pixels
// with two or four results (last column, last row) hold back the next pixel
// until their last result has issued. Reset is synchronous; line stores need
// no clearing. Output stalls back up through the pipe to in_tready.
module median_filter_3x3_rgb_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue[7:0], green[15:8], red[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // col, row, blue, green, red, zero fill
  output logic        out_tlast,
  output logic        out_tuser,  // frame_last
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import mf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [FW_W-1:0]  frame_width_r;
  logic [ROW_W-1:0] frame_height_r;
  logic [CW:0]      w_eff;
  logic [ROW_W-1:0] h_eff;

  logic [CW-1:0]    col_cnt_r, c_in;
  logic [ROW_W-1:0] row_cnt_r, r_in;
  logic             lastc_in, lastr_in;

  logic             in_acc;
  logic             s1_v_r;
  pixel_t           s1_px_r;
  logic [CW-1:0]    s1_c_r;
  logic [ROW_W-1:0] s1_r_r;
  logic             s1_lastc_r, s1_lastr_r;
  logic             move;

  pixel_t older_rd, newer_rd, older_eff, newer_eff;
  logic   fwd_r;
  pixel_t fwd_old_r, fwd_new_r;

  pixel_t wc0_r [3];
  pixel_t wc1_r [3];

  logic [3:0]       job_pend_r, pend_after, sel, mask_new;
  win_t             job_win_r, win_new;
  logic [CW-1:0]    job_c_r;
  logic [ROW_W-1:0] job_r_r;
  logic             issue, job_free, med_ready;

  logic       r_is_r, c_is_c;
  logic [2:0] rm, cm;
  logic [8:0] mask9;
  logic [3:0] cnt;
  rsl_ctl_t   ctl_issue, ctl_out;
  logic [2:0][7:0] med;
  logic       med_valid;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(frame_width_r);
    end
    h_eff = (frame_height_r == '0) ? ROW_W'(1) : frame_height_r;
  end

  assign c_in     = ({1'b0, col_cnt_r} >= w_eff) ? '0 : col_cnt_r;
  assign r_in     = (row_cnt_r >= h_eff) ? '0 : row_cnt_r;
  assign lastc_in = ({1'b0, c_in} == w_eff - (CW+1)'(1));
  assign lastr_in = (r_in == h_eff - ROW_W'(1));

  assign in_tready = !s1_v_r || move;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_W'(640);
      frame_height_r <= ROW_W'(480);
      col_cnt_r      <= '0;
      row_cnt_r      <= '0;
      s1_v_r         <= 1'b0;
      fwd_r          <= 1'b0;
      job_pend_r     <= '0;
      for (int i = 0; i < 3; i++) begin
        wc0_r[i] <= '0;
        wc1_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FW_W-1:0];
          REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        s1_v_r <= 1'b1;
        if (lastc_in) begin
          col_cnt_r <= '0;
          row_cnt_r <= lastr_in ? '0 : r_in + ROW_W'(1);
        end else begin
          col_cnt_r <= c_in + CW'(1);
          row_cnt_r <= r_in;
        end
        fwd_r <= move && (s1_c_r == c_in);
      end else if (move) begin
        s1_v_r <= 1'b0;
      end
      if (move) begin
        job_pend_r <= mask_new;
        for (int i = 0; i < 3; i++) begin
          wc0_r[i] <= wc1_r[i];
        end
        wc1_r[0] <= older_eff;
        wc1_r[1] <= newer_eff;
        wc1_r[2] <= s1_px_r;
      end else if (issue) begin
        job_pend_r <= pend_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r    <= in_tdata;
      s1_c_r     <= c_in;
      s1_r_r     <= r_in;
      s1_lastc_r <= lastc_in;
      s1_lastr_r <= lastr_in;
      fwd_old_r  <= newer_eff;
      fwd_new_r  <= s1_px_r;
    end
    if (move) begin
      job_win_r <= win_new;
      job_c_r   <= s1_c_r;
      job_r_r   <= s1_r_r;
    end
  end

  mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (move),
    .waddr (s1_c_r),
    .wdata (newer_eff),
    .re    (in_acc),
    .raddr (c_in),
    .rdata (older_rd)
  );

  mf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk   (clk),
    .we    (move),
    .waddr (s1_c_r),
    .wdata (s1_px_r),
    .re    (in_acc),
    .raddr (c_in),
    .rdata (newer_rd)
  );

  assign older_eff = fwd_r ? fwd_old_r : older_rd;
  assign newer_eff = fwd_r ? fwd_new_r : newer_rd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_new[i*3]     = wc0_r[i];
      win_new[i*3 + 1] = wc1_r[i];
    end
    win_new[2] = older_eff;
    win_new[5] = newer_eff;
    win_new[8] = s1_px_r;
    mask_new[0] = (s1_r_r != '0) && (s1_c_r != '0);
    mask_new[1] = (s1_r_r != '0) && s1_lastc_r;
    mask_new[2] = s1_lastr_r && (s1_c_r != '0);
    mask_new[3] = s1_lastr_r && s1_lastc_r;
  end

  assign sel        = job_pend_r & (~job_pend_r + 4'd1);
  assign pend_after = job_pend_r & ~sel;
  assign issue      = (job_pend_r != '0) && med_ready;
  assign job_free   = (job_pend_r == '0) || (issue && pend_after == '0);
  assign move       = s1_v_r && job_free;

  always_comb begin
    r_is_r = sel[2] | sel[3];
    c_is_c = sel[1] | sel[3];
    rm = r_is_r ? {1'b1, job_r_r != '0, 1'b0} : {2'b11, job_r_r > ROW_W'(1)};
    cm = c_is_c ? {1'b1, job_c_r != '0, 1'b0} : {2'b11, job_c_r > CW'(1)};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mask9[i*3 + j] = rm[i] & cm[j];
      end
    end
    cnt = 4'($countones(rm)) * 4'($countones(cm));
    ctl_issue.col        = COL_W'(c_is_c ? job_c_r : job_c_r - CW'(1));
    ctl_issue.row        = r_is_r ? job_r_r : job_r_r - ROW_W'(1);
    ctl_issue.run_last   = (pend_after == '0);
    ctl_issue.frame_last = sel[3];
  end

  mf3_median u_median (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (job_pend_r != '0),
    .i_ready (med_ready),
    .i_win   (job_win_r),
    .i_mask  (mask9),
    .i_cnt   (cnt),
    .i_ctl   (ctl_issue),
    .o_valid (med_valid),
    .o_ready (out_tready),
    .o_med   (med),
    .o_ctl   (ctl_out)
  );

  assign out_tvalid = med_valid;
  assign out_tdata  = {6'b0, med[2], med[1], med[0], ctl_out.row, ctl_out.col};
  assign out_tlast  = ctl_out.run_last;
  assign out_tuser  = ctl_out.frame_last;

  a_frame_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    issue && sel[3] |-> pend_after == '0)
    else $error("frame end result is not the last of its run");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted pixel lost before line store stage");

  a_corner_pending: assert property (@(posedge clk) disable iff (!rst_n)
    move && s1_lastr_r && s1_lastc_r |=> job_pend_r[3])
    else $error("bottom-right result not scheduled");

endmodule
